>>> design/ddsp_pkg.sv
// Shared types and constants of the disk data separator PLL step.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ddsp_pkg;

    // Field widths and fixed-point format.
    localparam int POS_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = 32;
    localparam int GAIN_W    = 12;
    localparam int ERR_W     = POS_W + 2;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int STEP_W    = POS_W + 4;

    // Loop filter denominator, 24 cells in Q8.8, and its power-of-two part.
    localparam int DENOM     = 24 << FRAC_BITS;
    localparam int DIV_SHIFT = FRAC_BITS + 3;

    // Shared multiply-accumulate unit.
    localparam int A_W    = SUM_W + 1;
    localparam int B_W    = 24;
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = 48;

    // Clamp bounds: floor(v / 50) as (v * RECIP_50) >> BOUND_SHIFT.
    localparam int BND_W       = 22;
    localparam int LIM_W       = POS_W + 1;
    localparam int BOUND_SHIFT = 27;
    localparam int RECIP_50    = 2684355;

    // Final divide by three: floor(x / 3) as (x * RECIP_3) >> RECIP3_SHIFT.
    localparam int QUO_W        = 14;
    localparam int RECIP_3      = 43691;
    localparam int RECIP3_SHIFT = 17;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0]  REF_RESET  = POS_W'(4096);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    // Configuration register indexes.
    localparam logic CFG_REF  = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    // Steps of the multiply-accumulate sequence.
    localparam logic [3:0] OP_REF  = 4'd0;
    localparam logic [3:0] OP_STEP = 4'd1;
    localparam logic [3:0] OP_ERR  = 4'd2;
    localparam logic [3:0] OP_DIFF = 4'd3;
    localparam logic [3:0] OP_ESUM = 4'd4;
    localparam logic [3:0] OP_LO   = 4'd5;
    localparam logic [3:0] OP_HI   = 4'd6;
    localparam logic [3:0] OP_BASE = 4'd7;
    localparam logic [3:0] OP_WAIT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MAC,
        ST_DIV,
        ST_FIN
    } ddsp_state_t;

    typedef struct packed {
        logic issue;
        logic acc_en;
        logic clear;
    } ddsp_mac_ctrl_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  err_sum;
        logic signed [SUM_W-1:0]  step_sum;
    } ddsp_phase_t;

endpackage

`default_nettype wire

>>> design/ddsp_mac.sv
// Shared multiply-accumulate unit of the PLL step.
// Depends on ddsp_pkg for widths and the control struct.
`default_nettype none

module ddsp_mac
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ddsp_pkg::ddsp_mac_ctrl_t           ctrl,
    input  wire logic signed [ddsp_pkg::A_W-1:0]    a,
    input  wire logic signed [ddsp_pkg::B_W-1:0]    b,
    output logic signed [ddsp_pkg::PROD_W-1:0]      prod,
    output logic signed [ddsp_pkg::ACC_W-1:0]       acc
);

    logic signed [ddsp_pkg::PROD_W-1:0] prod_reg;
    logic signed [ddsp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ddsp_pkg::ACC_W-1:0]  acc_next;
    logic                               pend_reg;

    // The product is registered; it is added into the accumulator in the following cycle.
    always_comb
    begin
        if (ctrl.clear)
        begin
            acc_next = ddsp_pkg::ACC_W'(ddsp_pkg::DENOM / 2);
        end
        else if (pend_reg)
        begin
            acc_next = acc_reg + $signed(prod_reg[ddsp_pkg::ACC_W-1:0]);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctrl.issue & ctrl.acc_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= a * b;
        end
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

>>> design/ddsp_phase.sv
// Phase detector and saturating integrators of the PLL step.
// Depends on ddsp_pkg for widths and the phase result struct.
`default_nettype none

module ddsp_phase
(
    input  wire logic        [ddsp_pkg::POS_W-1:0] pos,
    input  wire logic        [ddsp_pkg::POS_W-1:0] last_pos,
    input  wire logic        [ddsp_pkg::POS_W-1:0] cell_len,
    input  wire logic        [ddsp_pkg::POS_W-1:0] cell_mid,
    input  wire logic signed [ddsp_pkg::ERR_W-1:0] last_err,
    input  wire logic signed [ddsp_pkg::SUM_W-1:0] err_sum,
    input  wire logic signed [ddsp_pkg::SUM_W-1:0] step_sum,
    output ddsp_pkg::ddsp_phase_t                  phase
);

    localparam int PAD = ddsp_pkg::STEP_W - ddsp_pkg::POS_W;
    localparam int SW  = ddsp_pkg::SUM_W;

    logic signed [ddsp_pkg::STEP_W-1:0] step_raw;
    logic signed [ddsp_pkg::STEP_W-1:0] step_twice;
    logic signed [ddsp_pkg::STEP_W-1:0] len_ext;
    logic signed [ddsp_pkg::STEP_W-1:0] step;
    logic signed [ddsp_pkg::ERR_W-1:0]  err;
    logic signed [SW:0]                 esum_wide;
    logic signed [SW:0]                 ssum_wide;

    function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] v);
        logic signed [SW-1:0] r;
        if (v[SW] != v[SW-1])
        begin
            r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        step_raw   = $signed({{PAD{1'b0}}, last_pos}) - $signed({{PAD{1'b0}}, pos});
        step_twice = step_raw <<< 1;
        len_ext    = $signed({{PAD{1'b0}}, cell_len});

        // Wrap the pulse-to-pulse step into plus or minus half a cell.
        priority if (step_twice > len_ext)
        begin
            step = step_raw - len_ext;
        end
        else if (step_twice < -len_ext)
        begin
            step = step_raw + len_ext;
        end
        else
        begin
            step = step_raw;
        end

        err = $signed({2'b00, cell_mid}) - $signed({2'b00, pos});

        esum_wide = $signed({err_sum[SW-1], err_sum})
                  + $signed({{(SW + 1 - ddsp_pkg::ERR_W){err[ddsp_pkg::ERR_W-1]}}, err});
        ssum_wide = $signed({step_sum[SW-1], step_sum})
                  + $signed({{(SW + 1 - ddsp_pkg::STEP_W){step[ddsp_pkg::STEP_W-1]}}, step});

        phase.err      = err;
        phase.diff     = $signed({err[ddsp_pkg::ERR_W-1], err})
                       - $signed({last_err[ddsp_pkg::ERR_W-1], last_err});
        phase.err_sum  = sat_sum(esum_wide);
        phase.step_sum = sat_sum(ssum_wide);
    end

endmodule

`default_nettype wire

>>> design/disk_data_separator_pll_step.sv
// Top level of the disk data separator PLL step; uses ddsp_pkg, ddsp_phase, ddsp_mac.
// A new pulse item is taken only in the idle state, after the previous one has passed the
// phase state, the nine-step sequence of the shared multiply-accumulate unit, the
// range-test state and the finish state, which waits for room in the output register.
// Reset (rst_n, asynchronous, active low) clears the loop state, sets the cell
// length to 4096 and its middle to 2048, and loads the register reset values.
`default_nettype none

module disk_data_separator_pll_step
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream. s_tdata fields from bit 0: pulse_position[15:0].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // Result stream. m_tdata fields from bit 0: pulse_position_echo[15:0],
    // adjusted_cell_size[31:16], new_cell_center[47:32], size_clamped[48], zeros above.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    // Configuration writes: index 0 reference_cell_size, index 1 loop_gain.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int POS_W  = ddsp_pkg::POS_W;
    localparam int ERR_W  = ddsp_pkg::ERR_W;
    localparam int DIFF_W = ddsp_pkg::DIFF_W;
    localparam int SUM_W  = ddsp_pkg::SUM_W;
    localparam int A_W    = ddsp_pkg::A_W;
    localparam int B_W    = ddsp_pkg::B_W;
    localparam int LIM_W  = ddsp_pkg::LIM_W;
    localparam int X_W    = ddsp_pkg::ACC_W - ddsp_pkg::DIV_SHIFT;
    localparam int QUO_W  = ddsp_pkg::QUO_W;
    localparam int SIZE_W = LIM_W + 1;

    // Control and loop state.
    ddsp_pkg::ddsp_state_t state_reg, state_next;
    logic [3:0]            op_reg, op_next;
    logic                  m_valid_reg, m_valid_next;

    logic [POS_W-1:0]              ref_reg;
    logic [ddsp_pkg::GAIN_W-1:0]   gain_reg;
    logic [POS_W-1:0]              last_pos_reg;
    logic signed [ERR_W-1:0]       last_err_reg;
    logic signed [SUM_W-1:0]       err_sum_reg;
    logic signed [SUM_W-1:0]       step_sum_reg;
    logic [POS_W-1:0]              cell_len_reg;
    logic [POS_W-1:0]              cell_mid_reg;

    // Payload registers of the item in work and of the waiting result.
    logic [POS_W-1:0]        pos_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [LIM_W-1:0]        lo_reg;
    logic [LIM_W-1:0]        hi_reg;
    logic                    low_reg;
    logic                    high_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic [POS_W-1:0]        out_size_reg;
    logic [POS_W-1:0]        out_mid_reg;
    logic                    out_clamp_reg;

    ddsp_pkg::ddsp_phase_t    phase;
    ddsp_pkg::ddsp_mac_ctrl_t mac_ctrl;
    logic signed [A_W-1:0]    mac_a;
    logic signed [B_W-1:0]    mac_b;
    logic signed [ddsp_pkg::PROD_W-1:0] mac_prod;
    logic signed [ddsp_pkg::ACC_W-1:0]  mac_acc;

    logic [ddsp_pkg::BND_W-1:0] lo_num;
    logic [ddsp_pkg::BND_W-1:0] hi_num;
    logic [SIZE_W-1:0]          span;
    logic [SIZE_W+1:0]          limit;
    logic [X_W-1:0]             x_val;
    logic                       r_neg;
    logic                       r_high;
    logic [QUO_W-1:0]           quo;
    logic [SIZE_W-1:0]          size_wide;
    logic [POS_W-1:0]           size_final;
    logic                       fin_load;

    ddsp_phase u_phase
    (
        .pos      (pos_reg),
        .last_pos (last_pos_reg),
        .cell_len (cell_len_reg),
        .cell_mid (cell_mid_reg),
        .last_err (last_err_reg),
        .err_sum  (err_sum_reg),
        .step_sum (step_sum_reg),
        .phase    (phase)
    );

    ddsp_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mac_a),
        .b     (mac_b),
        .prod  (mac_prod),
        .acc   (mac_acc)
    );

    // Rounded clamp bounds 49/50 and 51/50 of the reference, before the divide by 50.
    assign lo_num = ddsp_pkg::BND_W'(ref_reg) * ddsp_pkg::BND_W'(49) + ddsp_pkg::BND_W'(25);
    assign hi_num = ddsp_pkg::BND_W'(ref_reg) * ddsp_pkg::BND_W'(51) + ddsp_pkg::BND_W'(25);

    // After the sequence the accumulator holds r = N + D/2 - lo*D. The size is
    // lo + floor(r / D), with D = 3 * 2^DIV_SHIFT. A negative r means the low
    // clamp; floor(r / 2^DIV_SHIFT) at or above 3*(hi-lo+1) means the high clamp.
    assign span   = {1'b0, hi_reg} - {1'b0, lo_reg} + SIZE_W'(1);
    assign limit  = (SIZE_W+2)'(span) * (SIZE_W+2)'(3);
    assign r_neg  = mac_acc[ddsp_pkg::ACC_W-1];
    assign x_val  = mac_acc[ddsp_pkg::ACC_W-1:ddsp_pkg::DIV_SHIFT];
    assign r_high = !r_neg && (x_val >= X_W'(limit));

    assign quo = mac_prod[ddsp_pkg::RECIP3_SHIFT+QUO_W-1:ddsp_pkg::RECIP3_SHIFT];

    always_comb
    begin
        priority if (low_reg)
        begin
            size_wide = {1'b0, lo_reg};
        end
        else if (high_reg)
        begin
            size_wide = {1'b0, hi_reg};
        end
        else
        begin
            size_wide = {1'b0, lo_reg} + SIZE_W'(quo);
        end
        // A size past the field range saturates without counting as clamped.
        if (size_wide > SIZE_W'({POS_W{1'b1}}))
        begin
            size_final = {POS_W{1'b1}};
        end
        else
        begin
            size_final = size_wide[POS_W-1:0];
        end
    end

    // Sequencer: next state and the operands of the shared unit.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        mac_ctrl.issue  = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_a           = '0;
        mac_b           = '0;
        fin_load        = 1'b0;

        unique case (state_reg)
            ddsp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ddsp_pkg::ST_PHASE;
                end
            end
            ddsp_pkg::ST_PHASE:
            begin
                mac_ctrl.clear = 1'b1;
                op_next        = ddsp_pkg::OP_REF;
                state_next     = ddsp_pkg::ST_MAC;
            end
            ddsp_pkg::ST_MAC:
            begin
                op_next = op_reg + 4'd1;
                unique case (op_reg)
                    ddsp_pkg::OP_REF:
                    begin
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({{(A_W-POS_W){1'b0}}, ref_reg});
                        mac_b = B_W'(ddsp_pkg::DENOM);
                    end
                    ddsp_pkg::OP_STEP:
                    begin
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({step_sum_reg[SUM_W-1], step_sum_reg});
                        mac_b = -$signed({{(B_W-ddsp_pkg::GAIN_W){1'b0}}, gain_reg});
                    end
                    ddsp_pkg::OP_ERR:
                    begin
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({{(A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg});
                        mac_b = -B_W'(ddsp_pkg::DENOM / 2);
                    end
                    ddsp_pkg::OP_DIFF:
                    begin
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({{(A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg});
                        mac_b = B_W'(ddsp_pkg::DENOM / 8);
                    end
                    ddsp_pkg::OP_ESUM:
                    begin
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({err_sum_reg[SUM_W-1], err_sum_reg});
                        mac_b = -B_W'(ddsp_pkg::DENOM / 128);
                    end
                    ddsp_pkg::OP_LO:
                    begin
                        mac_ctrl.issue = 1'b1;
                        mac_a = $signed({{(A_W-ddsp_pkg::BND_W){1'b0}}, lo_num});
                        mac_b = B_W'(ddsp_pkg::RECIP_50);
                    end
                    ddsp_pkg::OP_HI:
                    begin
                        mac_ctrl.issue = 1'b1;
                        mac_a = $signed({{(A_W-ddsp_pkg::BND_W){1'b0}}, hi_num});
                        mac_b = B_W'(ddsp_pkg::RECIP_50);
                    end
                    ddsp_pkg::OP_BASE:
                    begin
                        // Lower bound was captured in the previous cycle.
                        mac_ctrl.issue  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_a = $signed({{(A_W-LIM_W){1'b0}}, lo_reg});
                        mac_b = -B_W'(ddsp_pkg::DENOM);
                    end
                    ddsp_pkg::OP_WAIT:
                    begin
                        state_next = ddsp_pkg::ST_DIV;
                    end
                    default:
                    begin
                        state_next = ddsp_pkg::ST_DIV;
                    end
                endcase
            end
            ddsp_pkg::ST_DIV:
            begin
                mac_ctrl.issue = 1'b1;
                mac_a = $signed({{(A_W-QUO_W){1'b0}}, x_val[QUO_W-1:0]});
                mac_b = B_W'(ddsp_pkg::RECIP_3);
                state_next = ddsp_pkg::ST_FIN;
            end
            ddsp_pkg::ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    fin_load   = 1'b1;
                    state_next = ddsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddsp_pkg::ST_IDLE;
            end
        endcase

        if (fin_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ddsp_pkg::ST_IDLE;
            op_reg       <= ddsp_pkg::OP_REF;
            m_valid_reg  <= 1'b0;
            ref_reg      <= ddsp_pkg::REF_RESET;
            gain_reg     <= ddsp_pkg::GAIN_RESET;
            last_pos_reg <= '0;
            last_err_reg <= '0;
            err_sum_reg  <= '0;
            step_sum_reg <= '0;
            cell_len_reg <= ddsp_pkg::REF_RESET;
            cell_mid_reg <= ddsp_pkg::REF_RESET >> 1;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ddsp_pkg::CFG_REF:  ref_reg  <= cfg_data;
                    ddsp_pkg::CFG_GAIN: gain_reg <= cfg_data[ddsp_pkg::GAIN_W-1:0];
                    default:            ref_reg  <= ref_reg;
                endcase
            end

            // The phase cycle advances the detector and both integrators.
            if (state_reg == ddsp_pkg::ST_PHASE)
            begin
                last_pos_reg <= pos_reg;
                last_err_reg <= phase.err;
                err_sum_reg  <= phase.err_sum;
                step_sum_reg <= phase.step_sum;
            end

            // The new cell length takes effect when its result is handed over.
            if (fin_load)
            begin
                cell_len_reg <= size_final;
                cell_mid_reg <= size_final >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ddsp_pkg::ST_IDLE && s_tvalid)
        begin
            pos_reg <= s_tdata;
        end
        if (state_reg == ddsp_pkg::ST_PHASE)
        begin
            err_reg  <= phase.err;
            diff_reg <= phase.diff;
        end
        if (state_reg == ddsp_pkg::ST_MAC && op_reg == ddsp_pkg::OP_HI)
        begin
            lo_reg <= mac_prod[ddsp_pkg::BOUND_SHIFT+LIM_W-1:ddsp_pkg::BOUND_SHIFT];
        end
        if (state_reg == ddsp_pkg::ST_MAC && op_reg == ddsp_pkg::OP_BASE)
        begin
            hi_reg <= mac_prod[ddsp_pkg::BOUND_SHIFT+LIM_W-1:ddsp_pkg::BOUND_SHIFT];
        end
        if (state_reg == ddsp_pkg::ST_DIV)
        begin
            low_reg  <= r_neg;
            high_reg <= r_high;
        end
        if (fin_load)
        begin
            out_pos_reg   <= pos_reg;
            out_size_reg  <= size_final;
            out_mid_reg   <= size_final >> 1;
            out_clamp_reg <= low_reg | high_reg;
        end
    end

    assign s_tready  = (state_reg == ddsp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'b0, out_clamp_reg, out_mid_reg, out_size_reg, out_pos_reg};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the disk data separator PLL step.
// Depends on ddsp_pkg and disk_data_separator_pll_step; holds its own loop predictor.
`timescale 1ns / 100ps

module tb;

    localparam int POS_W     = ddsp_pkg::POS_W;
    localparam int FRAC_BITS = ddsp_pkg::FRAC_BITS;
    localparam int SUM_W     = ddsp_pkg::SUM_W;
    localparam int GAIN_W    = ddsp_pkg::GAIN_W;

    // Loop filter arithmetic in the same Q8.8 units as the block.
    localparam longint CELL_DIV  = longint'(24) << FRAC_BITS;
    localparam longint SUM_MAX   = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam longint POS_MAX   = (longint'(1) << POS_W) - 1;

    // Run shape.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int TRAIN_PHASES  = 7;
    localparam int TRAIN_ITEMS   = 95;
    localparam int SOAK_ITEMS    = 40;
    localparam int IDLE_PCT      = 24;
    localparam int TAIL_CYCLES   = 30;

    // One predicted output item of the block.
    typedef struct {
        logic [POS_W-1:0] echo;
        logic [POS_W-1:0] new_len;
        logic [POS_W-1:0] center;
        logic             clamped;
    } cell_update_t;

    // Scoreboard: tracks the loop state of the block, predicts the cell
    // update for each accepted pulse and checks the updates that come out.
    class pll_scoreboard;
        logic [POS_W-1:0]  ref_len;
        logic [GAIN_W-1:0] gain;
        logic [POS_W-1:0]  prev_pos;
        logic [POS_W-1:0]  cell_len;
        logic [POS_W-1:0]  cell_mid;
        longint            prev_err;
        longint            err_total;
        longint            step_total;
        cell_update_t      update_q[$];
        int                errors;

        function new();
            ref_len    = ddsp_pkg::REF_RESET;
            gain       = ddsp_pkg::GAIN_RESET;
            prev_pos   = '0;
            cell_len   = ddsp_pkg::REF_RESET;
            cell_mid   = ddsp_pkg::REF_RESET >> 1;
            prev_err   = 0;
            err_total  = 0;
            step_total = 0;
            errors     = 0;
        endfunction

        function longint clip_sum(longint v);
            if (v > SUM_MAX)
                return SUM_MAX;
            if (v < SUM_MIN)
                return SUM_MIN;
            return v;
        endfunction

        function void write_reg(logic index, logic [15:0] value);
            // The cell length and middle keep their values until the next pulse.
            if (index == ddsp_pkg::CFG_REF)
                ref_len = value[POS_W-1:0];
            else
                gain = value[GAIN_W-1:0];
        endfunction

        function void note_pulse(logic [POS_W-1:0] pos);
            longint       p;
            longint       len;
            longint       r;
            longint       step;
            longint       err;
            longint       diff;
            longint       num;
            longint       q;
            longint       lo;
            longint       hi;
            cell_update_t upd;
            p   = longint'(pos);
            len = longint'(cell_len);
            r   = longint'(ref_len);
            upd.clamped = 1'b0;

            // Pulse-to-pulse step, wrapped into half a cell either way.
            step = longint'(prev_pos) - p;
            if (2 * step > len)
                step = step - len;
            else if (2 * step < -len)
                step = step + len;

            err        = longint'(cell_mid) - p;
            diff       = err - prev_err;
            err_total  = clip_sum(err_total + err);
            prev_err   = err;
            step_total = clip_sum(step_total + step);

            num = r * CELL_DIV - step_total * longint'(gain)
                - (err * (CELL_DIV / 2) - diff * (CELL_DIV / 8)
                   + err_total * (CELL_DIV / 128));
            num = num + CELL_DIV / 2;
            q = num / CELL_DIV;
            if ((num % CELL_DIV) != 0 && num < 0)
                q = q - 1;

            lo = (r * 49 + 25) / 50;
            hi = (r * 51 + 25) / 50;
            if (q < lo)
            begin
                q = lo;
                upd.clamped = 1'b1;
            end
            else if (q > hi)
            begin
                q = hi;
                upd.clamped = 1'b1;
            end
            // Above the field range the length saturates without the clamp flag.
            if (q > POS_MAX)
                q = POS_MAX;

            cell_len = q[POS_W-1:0];
            cell_mid = cell_len >> 1;
            prev_pos = pos;

            upd.echo    = pos;
            upd.new_len = cell_len;
            upd.center  = cell_mid;
            update_q.push_back(upd);
        endfunction

        function int outstanding();
            return update_q.size();
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] word);
            cell_update_t want;
            if (update_q.size() == 0)
            begin
                $error("cell update 0x%014h arrived with nothing expected", word);
                errors++;
                return;
            end
            want = update_q.pop_front();
            compare_field("pulse_position_echo", want.echo, word[15:0]);
            compare_field("adjusted_cell_size", want.new_len, word[31:16]);
            compare_field("new_cell_center", want.center, word[47:32]);
            compare_field("size_clamped", want.clamped, word[48]);
        endfunction
    endclass

    // Every input of the block starts from a known value.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = ddsp_pkg::CFG_REF;
    logic [15:0] cfg_data  = '0;

    // When set, neither side idles: the pulse source sends back to back and
    // the result sink never stalls.
    bit            steady      = 1'b0;
    int            cycle_count = 0;
    pll_scoreboard board;

    disk_data_separator_pll_step i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result sink. Handshakes are sampled at the rising edge, before any of
    // this edge's updates land, and m_tready is changed for the next edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one pulse item and waits until the block takes it. A random gap
    // may come first; tvalid is left high so that the next item can follow
    // in the very next cycle.
    task automatic send_pulse(logic [15:0] pos);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_pulse(pos);
    endtask

    // Stops the pulse source and waits until every predicted update has come
    // back. Each pulse causes one update, so the block is idle afterwards.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    task automatic program_reg(logic index, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A pulse train: mostly pulses near the current cell middle, as a locked
    // separator would see them, with the rest anywhere in the field.
    task automatic send_train(int count);
        int span;
        int p;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
            begin
                span = int'(board.cell_len) / 2;
                p = int'(board.cell_mid) + int'($urandom_range(0, span)) - span / 2;
                if (p < 0)
                    p = 0;
                if (p > int'(POS_MAX))
                    p = int'(POS_MAX);
            end
            else
            begin
                p = int'($urandom_range(0, int'(POS_MAX)));
            end
            send_pulse(p[15:0]);
        end
    endtask

    // Reset values first: on center, both field extremes, wraps of the step
    // in either direction, a small unwrapped step and alternating bits.
    logic [15:0] opening [9] = '{16'd2048, 16'd0, 16'hFFFF, 16'd0, 16'd1000,
                                 16'd3500, 16'd3400, 16'hAAAA, 16'h5555};

    initial
    begin
        logic [15:0] ref_pick;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_pulse(opening[i]);

        // Largest reference: the upper clamp bound lies above the field, so a
        // length just above it saturates without the clamp flag. Pulses a
        // little late keep pushing the length up through that band.
        drain();
        program_reg(ddsp_pkg::CFG_REF, 16'hFFFF);
        program_reg(ddsp_pkg::CFG_GAIN, 16'h0000);
        send_pulse(16'd32767);
        repeat (8)
            send_pulse(board.cell_mid + 16'd200);
        send_pulse(16'hFFFF);
        send_pulse(16'd0);

        // Reference of zero pins length and middle to zero; the gain write
        // sets all upper data bits, which the block must drop.
        drain();
        program_reg(ddsp_pkg::CFG_REF, 16'h0000);
        program_reg(ddsp_pkg::CFG_GAIN, 16'hFFFF);
        send_pulse(16'd0);
        send_pulse(16'hFFFF);
        send_pulse(16'd300);

        // Smallest reference in the nominal range.
        drain();
        program_reg(ddsp_pkg::CFG_REF, 16'd256);
        program_reg(ddsp_pkg::CFG_GAIN, 16'h0ABC);
        send_pulse(16'd128);
        send_pulse(16'hFFFF);
        send_pulse(16'd0);

        // Random trains over several register settings. One phase runs with
        // no idling on either side.
        for (int k = 0; k < TRAIN_PHASES; k++)
        begin
            drain();
            case (k % 3)
                0: ref_pick = 16'($urandom_range(256, 65535));
                1: ref_pick = 16'($urandom_range(256, 2047));
                default: ref_pick = 16'($urandom_range(60000, 65535));
            endcase
            program_reg(ddsp_pkg::CFG_REF, ref_pick);
            if ($urandom_range(1) == 1)
                program_reg(ddsp_pkg::CFG_GAIN, 16'($urandom_range(0, 65535)));
            steady = (k == 3);
            send_train(TRAIN_ITEMS);
        end

        // Late pulses in a tiny cell, back to back: the length sits on a clamp
        // bound while the phase error sum runs steadily negative.
        drain();
        steady = 1'b1;
        program_reg(ddsp_pkg::CFG_REF, 16'd256);
        program_reg(ddsp_pkg::CFG_GAIN, 16'd0);
        repeat (SOAK_ITEMS)
            send_pulse(16'hFFFF);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/ddsp_pkg.sv
design/ddsp_mac.sv
design/ddsp_phase.sv
design/disk_data_separator_pll_step.sv
tb/sv/tb.sv
